// ===== rtl/multiplexed_software_timers_macros.svh =====
// ---------------------------------------------------------------------------
// multiplexed_software_timers_macros
// Assertion macros for the multiplexed software timers block.
// ---------------------------------------------------------------------------
`ifndef MULTIPLEXED_SOFTWARE_TIMERS_MACROS_SVH
`define MULTIPLEXED_SOFTWARE_TIMERS_MACROS_SVH
// implication checked on every clock edge outside reset
`define MST_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define MST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/mst_pkg.sv =====
// ---------------------------------------------------------------------------
// mst_pkg
// Shared types and constants of the multiplexed software timers.
// ---------------------------------------------------------------------------
package mst_pkg;
  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  localparam logic [1:0] CMD_DECLARE = 2'd0;
  localparam logic [1:0] CMD_CANCEL  = 2'd1;
  localparam logic [1:0] CMD_EXPIRE  = 2'd2;

  localparam logic [1:0] KIND_EXPIRED  = 2'd0;
  localparam logic [1:0] KIND_DECLARED = 2'd1;
  localparam logic [1:0] KIND_FULL     = 2'd2;
  localparam logic [1:0] KIND_DONE     = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] current_time;
    logic [31:0] duration;
    logic [3:0]  timer_index;
  } mst_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic        load_valid;
    logic [31:0] load_value;
    logic        last;
  } mst_out_t;
endpackage

// ===== rtl/mst_cell.sv =====
// ---------------------------------------------------------------------------
// mst_cell
// One timer slot. Holds its remaining time and live flag; the cells form a
// chain that shifts one position per cycle during a sweep, so every slot
// passes the head of the chain once.
// ---------------------------------------------------------------------------
module mst_cell import mst_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift,
  input  logic                 load_rem,
  input  logic [TIME_BITS-1:0] load_rem_val,
  input  logic                 load_live,
  input  logic                 load_live_val,
  input  logic [TIME_BITS-1:0] prev_rem,
  input  logic                 prev_live,
  output logic [TIME_BITS-1:0] rem,
  output logic                 live
);
  // shift from the neighbor, or direct write from the controller
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (shift) begin
      live <= prev_live;
    end else if (load_live) begin
      live <= load_live_val;
    end
    if (shift) begin
      rem <= prev_rem;
    end else if (load_rem) begin
      rem <= load_rem_val;
    end
  end
endmodule

// ===== rtl/multiplexed_software_timers.sv =====
// ---------------------------------------------------------------------------
// multiplexed_software_timers
// Table of relative timers sharing one physical countdown timer.
// ---------------------------------------------------------------------------
// Usage: raise start with an item on cmd_in while busy is low. The item is
// taken at that edge and busy is high from the next cycle. Results appear on
// res with res_valid high for exactly one cycle each; the receiver cannot
// stall. A command first gives expiry items (kind expired) and then one
// final item with last set, which carries the load value when the physical
// timer is reloaded.
// A command that does not age the table passes through the decide and final
// states and then shows its final item; busy falls with that item, and the
// next item can be taken from then on. A command that ages the table rotates
// the chain of NUM_TIMERS cells once, one slot a cycle, giving up to one
// expiry per cycle, and then shows its final item.
// One command is in work at a time.
// Reset (rst, synchronous) frees every slot and clears the pending timer;
// no clearing pass is needed.
// ---------------------------------------------------------------------------
module multiplexed_software_timers import mst_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  mst_in_t  cmd_in,
  output logic     busy,
  output logic     res_valid,
  output mst_out_t res
);
  `include "multiplexed_software_timers_macros.svh"

  localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam logic [CW-1:0] LAST_POS = CW'(NUM_TIMERS - 1);
  localparam logic [TIME_BITS-1:0] ALL_ONES = '1;

  typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_SWEEP, S_FINAL} state_t;

  state_t               state;
  logic [1:0]           cmd;
  logic [TIME_BITS-1:0] now, dur, elapsed, set_time;
  logic [3:0]           idx;
  logic [SW-1:0]        next_slot, free_slot, new_slot;
  logic                 next_valid, free_found, do_install;
  logic                 cancel_hit;
  logic [CW-1:0]        pos;
  logic [TIME_BITS-1:0] best;
  logic                 best_valid;
  logic [SW-1:0]        best_slot;

  logic [TIME_BITS-1:0] rem [NUM_TIMERS];
  logic                 live [NUM_TIMERS];
  logic [TIME_BITS-1:0] w_rem [NUM_TIMERS];
  logic                 w_live [NUM_TIMERS];
  logic                 ld_rem [NUM_TIMERS];
  logic                 ld_live [NUM_TIMERS];
  logic                 ld_live_val [NUM_TIMERS];
  logic                 shift;

  // head of the chain is cell 0; it feeds the tail with the aged value
  logic                 head_exp;
  logic [TIME_BITS-1:0] head_rem;
  assign head_exp = live[0] && !(elapsed < rem[0]);
  assign head_rem = rem[0] - elapsed;
  assign shift    = (state == S_SWEEP);

  // first free slot search (priority encoder over valid bits)
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
  end

  // cell chain
  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    localparam int NX = (g + 1) % NUM_TIMERS;
    if (g == NUM_TIMERS - 1) begin : g_tail
      assign w_rem[g]  = head_rem;
      assign w_live[g] = live[0] && !head_exp;
    end else begin : g_mid
      assign w_rem[g]  = rem[NX];
      assign w_live[g] = live[NX];
    end
    mst_cell #(.TIME_BITS(TIME_BITS)) u_cell (
      .clk(clk), .rst(rst), .shift(shift),
      .load_rem(ld_rem[g]), .load_rem_val(dur),
      .load_live(ld_live[g]), .load_live_val(ld_live_val[g]),
      .prev_rem(w_rem[g]), .prev_live(w_live[g]),
      .rem(rem[g]), .live(live[g])
    );
  end

  // direct cell writes: install a declared slot, free a cancelled slot
  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      ld_rem[i]      = 1'b0;
      ld_live[i]     = 1'b0;
      ld_live_val[i] = 1'b0;
    end
    if (state == S_DECIDE && cmd == CMD_DECLARE && free_found) begin
      ld_rem[free_slot] = 1'b1;
      if (do_install) begin
        ld_live[free_slot]     = 1'b1;
        ld_live_val[free_slot] = 1'b1;
      end
    end
    if (state == S_DECIDE && cmd == CMD_CANCEL && {28'd0, idx} < 32'(NUM_TIMERS)) begin
      ld_live[SW'(idx)] = 1'b1;
    end
    // an aging declare goes live once the sweep is done
    if (state == S_FINAL && pos == CW'(NUM_TIMERS) && cmd == CMD_DECLARE) begin
      ld_rem[new_slot]      = 1'b1;
      ld_live[new_slot]     = 1'b1;
      ld_live_val[new_slot] = 1'b1;
    end
  end

  // declare installs without aging unless a timer is pending and it becomes the soonest
  logic [TIME_BITS:0] lhs, rhs;
  logic               shorter;
  assign lhs     = {1'b0, dur} + {1'b0, now};
  assign rhs     = {1'b0, rem[next_slot]} + {1'b0, set_time};
  assign shorter = lhs < rhs;
  assign do_install = !next_valid || !shorter;

  // cancel of the pending slot ages the table
  assign cancel_hit = (cmd == CMD_CANCEL) && ({28'd0, idx} < 32'(NUM_TIMERS)) &&
                      live[SW'(idx)] && next_valid && (next_slot == SW'(idx));

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      busy       <= 1'b0;
      res_valid  <= 1'b0;
      next_valid <= 1'b0;
      next_slot  <= '0;
      set_time   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          res_valid <= 1'b0;
          if (start) begin
            cmd   <= cmd_in.cmd;
            now   <= TIME_BITS'(cmd_in.current_time);
            dur   <= TIME_BITS'(cmd_in.duration);
            idx   <= cmd_in.timer_index;
            busy  <= 1'b1;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_valid  <= 1'b0;
          elapsed    <= now - set_time;
          pos        <= '0;
          best       <= ALL_ONES;
          best_valid <= 1'b0;
          best_slot  <= '0;
          new_slot   <= free_slot;
          res.last   <= 1'b1;
          if (cmd == CMD_DECLARE && !free_found) begin
            res.kind       <= KIND_FULL;
            res.slot       <= '0;
            res.load_valid <= 1'b0;
            res.load_value <= '0;
            state          <= S_FINAL;
          end else if (cmd == CMD_DECLARE && !next_valid) begin
            set_time       <= now;
            next_slot      <= free_slot;
            next_valid     <= 1'b1;
            res.kind       <= KIND_DECLARED;
            res.slot       <= 4'(free_slot);
            res.load_valid <= 1'b1;
            res.load_value <= 32'(dur);
            state          <= S_FINAL;
          end else if (cmd == CMD_DECLARE && !shorter) begin
            res.kind       <= KIND_DECLARED;
            res.slot       <= 4'(free_slot);
            res.load_valid <= 1'b0;
            res.load_value <= '0;
            state          <= S_FINAL;
          end else if (cmd == CMD_DECLARE || cmd == CMD_EXPIRE || cancel_hit) begin
            state <= S_SWEEP;
          end else begin
            res.kind       <= KIND_DONE;
            res.slot       <= '0;
            res.load_valid <= 1'b0;
            res.load_value <= '0;
            state          <= S_FINAL;
          end
        end
        S_SWEEP: begin
          // head cell holds slot pos; it moves to the tail
          res_valid <= head_exp;
          if (head_exp) begin
            res.kind       <= KIND_EXPIRED;
            res.slot       <= 4'(pos);
            res.load_valid <= 1'b0;
            res.load_value <= '0;
            res.last       <= 1'b0;
          end else if (live[0] && head_rem < best) begin
            best       <= head_rem;
            best_slot  <= SW'(pos);
            best_valid <= 1'b1;
          end
          pos <= pos + 1'b1;
          if (pos == LAST_POS) begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          res_valid <= 1'b1;
          busy      <= 1'b0;
          state     <= S_IDLE;
          if (pos == CW'(NUM_TIMERS)) begin
            // a sweep just ran
            res.last <= 1'b1;
            if (cmd == CMD_DECLARE) begin
              set_time       <= now;
              next_slot      <= new_slot;
              next_valid     <= 1'b1;
              res.kind       <= KIND_DECLARED;
              res.slot       <= 4'(new_slot);
              res.load_valid <= 1'b1;
              res.load_value <= 32'(dur);
            end else begin
              next_valid     <= best_valid;
              next_slot      <= best_slot;
              res.kind       <= KIND_DONE;
              res.slot       <= '0;
              res.load_valid <= best_valid;
              if (best_valid) begin
                set_time       <= now;
                res.load_value <= 32'(best);
              end else begin
                res.load_value <= '0;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MST_ASSERT_IMP(a_busy_when_valid, clk, rst, res_valid && !res.last, busy)
  `MST_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `MST_ASSERT_IMP(a_next_live, clk, rst, !busy && next_valid, live[next_slot])
endmodule

// ===== bench/tb_multiplexed_software_timers.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_multiplexed_software_timers
// Self-checking bench for the multiplexed software timers. A clocked driver
// issues commands from a queue, a clocked monitor compares each result item
// with the oldest predicted one from a built-in model of the timer table.
// ---------------------------------------------------------------------------
module tb_multiplexed_software_timers;
  import mst_pkg::*;

  localparam int NT = 16;
  localparam logic [1:0] CMD_BAD = 2'd3;

  logic     clk;
  logic     rst;
  logic     start;
  mst_in_t  cmd_in;
  logic     busy;
  logic     res_valid;
  mst_out_t res;

  multiplexed_software_timers dut (
    .clk(clk), .rst(rst), .start(start), .cmd_in(cmd_in),
    .busy(busy), .res_valid(res_valid), .res(res)
  );

  // timer table model
  logic [31:0] tbl_left [NT];
  logic        tbl_live [NT];
  logic [3:0]  soon_slot;
  logic        soon_valid;
  logic [31:0] armed_at;

  mst_in_t  cmd_q [$];
  mst_out_t want_q [$];
  int       errors = 0;
  int       n_sent = 0;
  int       n_got = 0;
  int       n_expired = 0;
  int       send_idle_pct = 0;
  logic     hold_send = 1'b0;
  logic     took = 1'b0;
  logic [31:0] clock_now = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic mst_out_t mk(logic [1:0] k, logic [3:0] s, logic lv,
                                  logic [31:0] val, logic lst);
    mst_out_t r;
    r.kind = k; r.slot = s; r.load_valid = lv;
    r.load_value = lv ? val : 32'd0; r.last = lst;
    return r;
  endfunction

  // subtract elapsed time, report runouts, pick new soonest
  task automatic age_table(logic [31:0] elapsed);
    logic [32:0] best;
    best = {1'b0, 32'hFFFF_FFFF};
    soon_valid = 1'b0;
    soon_slot = '0;
    for (int i = 0; i < NT; i++) begin
      if (!tbl_live[i]) continue;
      if (elapsed < tbl_left[i]) begin
        tbl_left[i] = tbl_left[i] - elapsed;
        if ({1'b0, tbl_left[i]} < best) begin
          best = {1'b0, tbl_left[i]};
          soon_slot = i[3:0];
          soon_valid = 1'b1;
        end
      end else begin
        tbl_live[i] = 1'b0;
        want_q.push_back(mk(KIND_EXPIRED, i[3:0], 1'b0, 32'd0, 1'b0));
        n_expired++;
      end
    end
  endtask

  task automatic predict_timers(mst_in_t it);
    logic [31:0] elapsed;
    int s;
    logic lv;
    logic [31:0] lval;
    elapsed = it.current_time - armed_at;
    lv = 1'b0;
    lval = '0;
    case (it.cmd)
      CMD_DECLARE: begin
        s = NT;
        for (int i = NT - 1; i >= 0; i--) if (!tbl_live[i]) s = i;
        if (s == NT) begin
          want_q.push_back(mk(KIND_FULL, 4'd0, 1'b0, 32'd0, 1'b1));
        end else begin
          tbl_left[s] = it.duration;
          if (!soon_valid ||
              ({1'b0, it.duration} + {1'b0, it.current_time} <
               {1'b0, tbl_left[soon_slot]} + {1'b0, armed_at})) begin
            if (soon_valid) age_table(elapsed);
            armed_at = it.current_time;
            soon_slot = s[3:0];
            soon_valid = 1'b1;
            lv = 1'b1;
          end
          tbl_live[s] = 1'b1;
          want_q.push_back(mk(KIND_DECLARED, s[3:0], lv, it.duration, 1'b1));
        end
      end
      CMD_CANCEL: begin
        if (tbl_live[it.timer_index]) begin
          tbl_live[it.timer_index] = 1'b0;
          if (soon_valid && soon_slot == it.timer_index) begin
            age_table(elapsed);
            if (soon_valid) begin
              lv = 1'b1; lval = tbl_left[soon_slot]; armed_at = it.current_time;
            end
          end
        end
        want_q.push_back(mk(KIND_DONE, 4'd0, lv, lval, 1'b1));
      end
      CMD_EXPIRE: begin
        age_table(elapsed);
        if (soon_valid) begin
          lv = 1'b1; lval = tbl_left[soon_slot]; armed_at = it.current_time;
        end
        want_q.push_back(mk(KIND_DONE, 4'd0, lv, lval, 1'b1));
      end
      default: want_q.push_back(mk(KIND_DONE, 4'd0, 1'b0, 32'd0, 1'b1));
    endcase
  endtask

  // driver: hold an item until taken, then offer the next one, gaps at random
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      took = 1'b0;
    end else if (!start || took) begin
      took = 1'b0;
      if (!hold_send && cmd_q.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        cmd_in <= cmd_q.pop_front();
        start  <= 1'b1;
      end else begin
        start  <= 1'b0;
      end
    end
  end

  // acceptance is seen at the rising edge; predict its results
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      predict_timers(cmd_in);
      n_sent++;
      took = 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    mst_out_t w;
    if (!rst && res_valid) begin
      n_got++;
      if (want_q.size() == 0) begin
        $error("unexpected result item kind=%0d slot=%0d", res.kind, res.slot);
        errors++;
      end else begin
        w = want_q.pop_front();
        if (res.kind !== w.kind) begin
          $error("kind: expected %0d, got %0d", w.kind, res.kind); errors++;
        end
        if (res.slot !== w.slot) begin
          $error("slot: expected %0d, got %0d", w.slot, res.slot); errors++;
        end
        if (res.load_valid !== w.load_valid) begin
          $error("load_valid: expected %0d, got %0d", w.load_valid, res.load_valid);
          errors++;
        end
        if (res.load_value !== w.load_value) begin
          $error("load_value: expected %0h, got %0h", w.load_value, res.load_value);
          errors++;
        end
        if (res.last !== w.last) begin
          $error("last: expected %0d, got %0d", w.last, res.last); errors++;
        end
      end
    end
  end

  function automatic mst_in_t item(logic [1:0] c, logic [31:0] t, logic [31:0] d,
                                   logic [3:0] ix);
    mst_in_t r;
    r.cmd = c; r.current_time = t; r.duration = d; r.timer_index = ix;
    return r;
  endfunction

  // random item; time mostly advances a little, sometimes jumps anywhere
  function automatic mst_in_t rand_item();
    int p;
    logic [31:0] d;
    p = $urandom_range(99);
    if ($urandom_range(19) == 0) clock_now = $urandom();
    else clock_now = clock_now + $urandom_range(60);
    d = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(120);
    if (p < 45) return item(CMD_DECLARE, clock_now, d, 4'($urandom()));
    if (p < 65) return item(CMD_CANCEL, clock_now, $urandom(), 4'($urandom()));
    if (p < 97) return item(CMD_EXPIRE, clock_now, $urandom(), 4'($urandom()));
    return item(CMD_BAD, clock_now, $urandom(), 4'($urandom()));
  endfunction

  task automatic drain();
    while (cmd_q.size() > 0 || start) @(posedge clk);
    while (want_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd_in = '0;
    for (int i = 0; i < NT; i++) begin
      tbl_left[i] = '0; tbl_live[i] = 1'b0;
    end
    soon_slot = '0; soon_valid = 1'b0; armed_at = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty expire, odd command, cancel of free slot, fill table past full, cancels, expires
    cmd_q.push_back(item(CMD_EXPIRE, 32'd5, 32'd0, 4'd0));
    cmd_q.push_back(item(CMD_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
    cmd_q.push_back(item(CMD_CANCEL, 32'd6, 32'd0, 4'd15));
    cmd_q.push_back(item(CMD_DECLARE, 32'd10, 32'hFFFF_FFFF, 4'd0));
    cmd_q.push_back(item(CMD_DECLARE, 32'd11, 32'd100, 4'd0));
    cmd_q.push_back(item(CMD_DECLARE, 32'd12, 32'd0, 4'd0));
    for (int i = 0; i < 14; i++)
      cmd_q.push_back(item(CMD_DECLARE, 32'hFFFF_FFF0, 32'hFFFF_FF00 + i, 4'd0));
    cmd_q.push_back(item(CMD_CANCEL, 32'd20, 32'd0, 4'd2));
    cmd_q.push_back(item(CMD_CANCEL, 32'd50, 32'd0, 4'd1));
    cmd_q.push_back(item(CMD_EXPIRE, 32'hFFFF_FFFF, 32'd0, 4'd0));
    cmd_q.push_back(item(CMD_EXPIRE, 32'd3, 32'd0, 4'd0));
    drain();

    // random phases with varied sender idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 83 : (ph == 2) ? 19 : 0;
      for (int k = 0; k < 75; k++) cmd_q.push_back(rand_item());
      // mid-phase pause until all results are in
      while (cmd_q.size() > 35) @(posedge clk);
      hold_send = 1'b1;
      while (start) @(posedge clk);
      while (want_q.size() > 0) @(posedge clk);
      hold_send = 1'b0;
      drain();
    end

    repeat (NT + 10) @(posedge clk);
    $display("Ran %0d commands, checked %0d result items, %0d of them expiries.",
             n_sent, n_got, n_expired);
    if (errors == 0 && want_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mst_pkg.sv
rtl/mst_cell.sv
rtl/multiplexed_software_timers.sv
bench/tb_multiplexed_software_timers.sv
